// File: design/chirp_symbol_to_byte_decoder_core_assert.svh
// Assertion macros used by the chirp decoder controller.
`ifndef CHIRP_SYMBOL_TO_BYTE_DECODER_CORE_ASSERT_SVH
`define CHIRP_SYMBOL_TO_BYTE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSBD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/csbd_pkg.sv
// Types and constants of the chirp symbol to byte decoder.
`timescale 1ns / 1ps
`default_nettype none
package csbd_pkg;

   typedef logic [1:0]  csr_index_type;
   typedef logic [10:0] csr_data_type;

   localparam csr_index_type REG_BIN_OFFSET  = 2'd0;
   localparam csr_index_type REG_CODING_RATE = 2'd1;
   localparam csr_index_type REG_MAX_SYMBOLS = 2'd2;

   localparam logic [3:0] CR_MIN         = 4'd5;
   localparam logic [3:0] CR_MAX         = 4'd8;
   localparam logic [7:0] LIMIT_RESET    = 8'd220;
   localparam logic [7:0] LFSR_SEED      = 8'hFF;
   localparam logic [7:0] MIN_FRAME_LEN  = 8'd4;

   localparam logic [1:0] KIND_BYTE       = 2'd0;
   localparam logic [1:0] KIND_HDR_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_HDR_REJECT = 2'd2;
   localparam logic [1:0] KIND_ABORT      = 2'd3;

   typedef struct packed {
      logic [10:0] symbol_bin;
      logic        start_frame;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] data_byte;
      logic [7:0] frame_length;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic       frame_clear;
      logic       sym_write;
      logic       cnt_inc;
      logic       fill_clear;
      logic       dec_start;
      logic       dec_hdr;
      logic       dec_step;
      logic       take_header;
      logic       nib_load;
      logic       nib_step;
      logic       out_load;
      logic [1:0] out_kind;
      logic       out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic hdr_blk_done;
      logic blk_full;
      logic limit;
      logic fin;
      logic dec_last;
      logic hdr_sel;
      logic hdr_ok;
      logic nbytes_zero;
      logic emit_now;
      logic bytes_last;
      logic nib_last;
   } dp_status_type;

endpackage
`default_nettype wire

// File: design/csbd_datapath.sv
// Datapath: symbol store, deinterleaver, Hamming decode, dewhitening and result register.
`timescale 1ns / 1ps
`default_nettype none
module csbd_datapath #(
   parameter int SF = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  csbd_pkg::csr_index_type   csr_index,
   input  csbd_pkg::csr_data_type    csr_wdata,
   input  csbd_pkg::req_payload_type req_payload,
   input  csbd_pkg::dp_cmd_type      cmd,
   output csbd_pkg::dp_status_type   sts,
   output csbd_pkg::rsp_payload_type rsp_payload
);
   import csbd_pkg::*;

   localparam int HROWS     = SF - 2;
   localparam int NIW       = $clog2(SF);
   localparam int MAXB      = (SF + 1) / 2;
   localparam int BLW       = $clog2(MAXB + 1);
   localparam int HDR_PAIRS = (SF - 7) / 2;

   localparam logic [3:0] SYN_D3 = 4'd11;
   localparam logic [3:0] SYN_D2 = 4'd14;
   localparam logic [3:0] SYN_D1 = 4'd13;
   localparam logic [3:0] SYN_D0 = 4'd7;

   function automatic logic [3:0] hamming_fix(input logic [7:0] w);
      logic d0, d1, d2, d3;
      logic [3:0] syn;
      d0 = w[4];
      d1 = w[5];
      d2 = w[6];
      d3 = w[7];
      syn = {w[3] ^ d3 ^ d2 ^ d1, w[2] ^ d2 ^ d1 ^ d0,
             w[1] ^ d3 ^ d2 ^ d0, w[0] ^ d3 ^ d1 ^ d0};
      if (syn == SYN_D3) d3 = ~d3;
      else if (syn == SYN_D2) d2 = ~d2;
      else if (syn == SYN_D1) d1 = ~d1;
      else if (syn == SYN_D0) d0 = ~d0;
      return {d0, d1, d2, d3};
   endfunction

   // Diagonal deinterleave: the bit of symbol i that lands in codeword c.
   function automatic logic pick_bit(input logic [SF-1:0] g, input logic [2:0] i,
                                     input int c, input int rows);
      logic [4:0] t;
      logic b;
      t = 5'(i) + 5'(2 * rows - c - 1);
      for (int k = 0; k < 3; k++) begin
         if (t >= 5'(rows)) t = t - 5'(rows);
      end
      b = 1'b0;
      for (int j = 0; j < rows; j++) begin
         if (t == 5'(j)) b = g[rows-1-j];
      end
      return b;
   endfunction

   logic [10:0] offset_ff, offset_in;
   logic [3:0]  cr_ff, cr_in;
   logic [7:0]  max_ff, max_in;

   logic [10:0] sym_store [8];
   logic [7:0]  cw_ff [SF];
   logic [7:0]  cw_in [SF];

   logic [3:0]     fill_ff, fill_in;
   logic           pending_ff, pending_in;
   logic [3:0]     low_ff, low_in;
   logic [7:0]     lfsr_ff, lfsr_in;
   logic [7:0]     emitted_ff, emitted_in;
   logic [7:0]     target_ff, target_in;
   logic [7:0]     count_ff, count_in;
   logic [2:0]     dec_idx_ff, dec_idx_in;
   logic           hdr_sel_ff, hdr_sel_in;
   logic [NIW-1:0] nib_idx_ff, nib_idx_in;
   logic [BLW-1:0] bytes_left_ff, bytes_left_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [3:0]    fill_eff;
   logic [3:0]    crc;
   logic [11:0]   diff;
   logic [SF-1:0] a_val, g_pay, g_hdr;
   logic [2:0]    pos;
   logic [3:0]    pos_pay;
   logic [7:0]    cw_cur;
   logic [3:0]    nib_hdr, nib_pay, nib_raw, nib;
   logic [3:0]    h0, h1, h2, h3, h4;
   logic          c4, c3, c2, c1, c0;
   logic [7:0]    hdr_len;
   logic [4:0]    pay_pairs;
   logic [7:0]    remain;
   logic [7:0]    hdr_nb8;
   logic [BLW-1:0] nbytes;
   logic [7:0]    byte_val;

   assign fill_eff = req_payload.start_frame ? 4'd0 : fill_ff;
   assign crc = (cr_ff < CR_MIN) ? CR_MIN : ((cr_ff > CR_MAX) ? CR_MAX : cr_ff);

   // Symbol conditioning for the decode step.
   assign diff    = {1'b0, sym_store[dec_idx_ff]} - {1'b0, offset_ff};
   assign a_val   = diff[SF-1:0];
   assign g_pay   = a_val ^ (a_val >> 1);
   assign g_hdr   = SF'(a_val[SF-1:2] ^ (a_val[SF-1:2] >> 1));
   assign pos_pay = crc - 4'd1 - {1'b0, dec_idx_ff};
   assign pos     = hdr_sel_ff ? (3'd7 - dec_idx_ff) : pos_pay[2:0];

   always_comb begin
      for (int c = 0; c < SF; c++) begin
         logic b;
         if (hdr_sel_ff) begin
            b = (c < HROWS) ? pick_bit(g_hdr, dec_idx_ff, c, HROWS) : 1'b0;
         end else begin
            b = pick_bit(g_pay, dec_idx_ff, c, SF);
         end
         cw_in[c] = ((dec_idx_ff == 3'd0) ? 8'd0 : cw_ff[c]) | (8'(b) << pos);
      end
   end

   // Header checksum over the first three corrected nibbles, checked against the fourth and fifth.
   assign h0 = hamming_fix(cw_ff[0]);
   assign h1 = hamming_fix(cw_ff[1]);
   assign h2 = hamming_fix(cw_ff[2]);
   assign h3 = hamming_fix(cw_ff[3]);
   assign h4 = hamming_fix(cw_ff[4]);
   assign c4 = ^h0;
   assign c3 = h0[3] ^ h1[3] ^ h1[2] ^ h1[1] ^ h2[0];
   assign c2 = h0[2] ^ h1[3] ^ h1[0] ^ h2[3] ^ h2[1];
   assign c1 = h0[1] ^ h1[2] ^ h1[0] ^ h2[2] ^ h2[1] ^ h2[0];
   assign c0 = h0[0] ^ h1[1] ^ h2[3] ^ h2[2] ^ h2[1] ^ h2[0];
   assign hdr_len = {h0, h1};

   // Nibble selection for the dewhitening step.
   assign cw_cur  = cw_ff[nib_idx_ff];
   assign nib_hdr = hamming_fix(cw_cur);
   assign nib_raw = 4'(cw_cur >> (crc - 4'd4));
   assign nib_pay = {nib_raw[0], nib_raw[1], nib_raw[2], nib_raw[3]};
   assign nib     = hdr_sel_ff ? nib_hdr : nib_pay;
   assign byte_val = {nib, low_ff} ^ lfsr_ff;

   assign pay_pairs = (5'(pending_ff) + 5'(SF)) >> 1;
   assign remain    = target_ff - emitted_ff;
   assign hdr_nb8   = (8'(HDR_PAIRS) < hdr_len) ? 8'(HDR_PAIRS) : hdr_len;
   assign nbytes    = hdr_sel_ff ? BLW'(hdr_nb8)
                    : ((8'(pay_pairs) < remain) ? BLW'(pay_pairs) : BLW'(remain));

   always_comb begin
      sts.hdr_blk_done = (fill_eff == 4'd7);
      sts.blk_full     = (fill_ff >= crc);
      sts.limit        = (count_ff >= max_ff);
      sts.fin          = ({1'b0, emitted_ff} + 9'(pay_pairs)) >= {1'b0, target_ff};
      sts.dec_last     = hdr_sel_ff ? (dec_idx_ff == 3'd7) : (dec_idx_ff == 3'(crc - 4'd1));
      sts.hdr_sel      = hdr_sel_ff;
      sts.hdr_ok       = (h3[0] == c4) && (h4 == {c3, c2, c1, c0}) && (hdr_len >= MIN_FRAME_LEN);
      sts.nbytes_zero  = (hdr_nb8 == 8'd0);
      sts.emit_now     = pending_ff && (emitted_ff < target_ff);
      sts.bytes_last   = (bytes_left_ff == BLW'(1));
      // Header extra nibbles end at the last header codeword, payload at the last row.
      sts.nib_last     = (nib_idx_ff == (hdr_sel_ff ? NIW'(HROWS - 1) : NIW'(SF - 1)));
   end

   always_comb begin
      offset_in = offset_ff;
      cr_in     = cr_ff;
      max_in    = max_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_BIN_OFFSET:  offset_in = csr_wdata;
            REG_CODING_RATE: cr_in     = csr_wdata[3:0];
            REG_MAX_SYMBOLS: max_in    = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      fill_in       = fill_ff;
      pending_in    = pending_ff;
      low_in        = low_ff;
      lfsr_in       = lfsr_ff;
      emitted_in    = emitted_ff;
      target_in     = target_ff;
      count_in      = count_ff;
      dec_idx_in    = dec_idx_ff;
      hdr_sel_in    = hdr_sel_ff;
      nib_idx_in    = nib_idx_ff;
      bytes_left_in = bytes_left_ff;
      rsp_in        = rsp_ff;
      if (cmd.frame_clear) begin
         pending_in = 1'b0;
         low_in     = 4'd0;
         lfsr_in    = LFSR_SEED;
         emitted_in = 8'd0;
         target_in  = 8'd0;
         count_in   = 8'd0;
      end
      if (cmd.cnt_inc && (count_ff != 8'hFF)) count_in = count_ff + 8'd1;
      if (cmd.sym_write) fill_in = fill_eff + 4'd1;
      else if (cmd.fill_clear || cmd.take_header) fill_in = 4'd0;
      if (cmd.dec_start) begin
         dec_idx_in = 3'd0;
         hdr_sel_in = cmd.dec_hdr;
      end else if (cmd.dec_step) begin
         dec_idx_in = dec_idx_ff + 3'd1;
      end
      if (cmd.take_header) target_in = hdr_len;
      if (cmd.nib_load) begin
         nib_idx_in    = hdr_sel_ff ? NIW'(5) : NIW'(0);
         bytes_left_in = nbytes;
      end else if (cmd.nib_step) begin
         nib_idx_in = nib_idx_ff + NIW'(1);
         if (!pending_ff) begin
            low_in     = nib;
            pending_in = 1'b1;
         end else begin
            pending_in = 1'b0;
            lfsr_in    = {lfsr_ff[6:0], lfsr_ff[7] ^ lfsr_ff[5] ^ lfsr_ff[4] ^ lfsr_ff[3]};
            if (emitted_ff < target_ff) begin
               emitted_in    = emitted_ff + 8'd1;
               bytes_left_in = bytes_left_ff - BLW'(1);
            end
         end
      end
      if (cmd.out_load) begin
         rsp_in.result_kind  = cmd.out_kind;
         rsp_in.data_byte    = (cmd.out_kind == KIND_BYTE) ? byte_val : 8'd0;
         rsp_in.frame_length = ((cmd.out_kind == KIND_HDR_ACCEPT) ||
                                (cmd.out_kind == KIND_HDR_REJECT)) ? hdr_len : target_ff;
         rsp_in.last         = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= 11'd0;
         cr_ff         <= CR_MIN;
         max_ff        <= LIMIT_RESET;
         fill_ff       <= 4'd0;
         pending_ff    <= 1'b0;
         low_ff        <= 4'd0;
         lfsr_ff       <= LFSR_SEED;
         emitted_ff    <= 8'd0;
         target_ff     <= 8'd0;
         count_ff      <= 8'd0;
         dec_idx_ff    <= 3'd0;
         hdr_sel_ff    <= 1'b0;
         nib_idx_ff    <= '0;
         bytes_left_ff <= '0;
      end else begin
         offset_ff     <= offset_in;
         cr_ff         <= cr_in;
         max_ff        <= max_in;
         fill_ff       <= fill_in;
         pending_ff    <= pending_in;
         low_ff        <= low_in;
         lfsr_ff       <= lfsr_in;
         emitted_ff    <= emitted_in;
         target_ff     <= target_in;
         count_ff      <= count_in;
         dec_idx_ff    <= dec_idx_in;
         hdr_sel_ff    <= hdr_sel_in;
         nib_idx_ff    <= nib_idx_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.sym_write) sym_store[fill_eff[2:0]] <= req_payload.symbol_bin;
      if (cmd.dec_step) begin
         for (int c = 0; c < SF; c++) cw_ff[c] <= cw_in[c];
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// File: design/csbd_ctrl.sv
// Controller: frame phase, decode sequencing and result handshake.
`timescale 1ns / 1ps
`default_nettype none
`include "chirp_symbol_to_byte_decoder_core_assert.svh"
module csbd_ctrl #(
   parameter int SF = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_start,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  csbd_pkg::dp_status_type sts,
   output csbd_pkg::dp_cmd_type    cmd
);
   import csbd_pkg::*;

   localparam logic HAS_EXTRA = (SF > 7);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PAY  = 3'd1;
   localparam logic [2:0] S_DEC  = 3'd2;
   localparam logic [2:0] S_HDR  = 3'd3;
   localparam logic [2:0] S_NIB  = 3'd4;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic [1:0] ph_eff;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign ph_eff    = req_start ? PH_HEADER : phase_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.frame_clear = req_start;
               phase_in        = ph_eff;
               if (ph_eff == PH_HEADER) begin
                  cmd.sym_write = 1'b1;
                  if (sts.hdr_blk_done) begin
                     cmd.dec_start = 1'b1;
                     cmd.dec_hdr   = 1'b1;
                     state_in      = S_DEC;
                  end
               end else if (ph_eff == PH_PAYLOAD) begin
                  cmd.sym_write = 1'b1;
                  cmd.cnt_inc   = 1'b1;
                  state_in      = S_PAY;
               end
            end
         end
         S_PAY: begin
            // A block that ends the frame is always delivered, even at the limit.
            if (sts.blk_full && (sts.fin || !sts.limit)) begin
               cmd.fill_clear = 1'b1;
               cmd.dec_start  = 1'b1;
               state_in       = S_DEC;
               if (sts.fin) phase_in = PH_IDLE;
            end else if (sts.limit) begin
               if (slot_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = KIND_ABORT;
                  cmd.out_last = 1'b1;
                  phase_in     = PH_IDLE;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DEC: begin
            cmd.dec_step = 1'b1;
            if (sts.dec_last) begin
               if (sts.hdr_sel) begin
                  state_in = S_HDR;
               end else begin
                  cmd.nib_load = 1'b1;
                  state_in     = S_NIB;
               end
            end
         end
         S_HDR: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = sts.hdr_ok ? KIND_HDR_ACCEPT : KIND_HDR_REJECT;
               cmd.out_last = !sts.hdr_ok || sts.nbytes_zero;
               if (sts.hdr_ok) begin
                  cmd.take_header = 1'b1;
                  cmd.nib_load    = 1'b1;
                  phase_in        = PH_PAYLOAD;
                  state_in        = HAS_EXTRA ? S_NIB : S_IDLE;
               end else begin
                  phase_in = PH_IDLE;
                  state_in = S_IDLE;
               end
            end
         end
         S_NIB: begin
            if (!sts.emit_now || slot_free) begin
               cmd.nib_step = 1'b1;
               if (sts.emit_now) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = KIND_BYTE;
                  cmd.out_last = sts.bytes_last;
               end
               if (sts.nib_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CSBD_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_load, slot_free, "result overwritten before it was taken")
   `CSBD_ASSERT_NEXT(a_abort_idles, clock, reset, cmd.out_load && (cmd.out_kind == KIND_ABORT), phase_ff == PH_IDLE, "frame still open after abort")
   `CSBD_ASSERT_NEXT(a_dec_exit, clock, reset, state_ff == S_DEC, (state_ff == S_DEC) || (state_ff == S_HDR) || (state_ff == S_NIB), "bad exit from decode")

endmodule
`default_nettype wire

// File: design/chirp_symbol_to_byte_decoder_core.sv
// Top level of the chirp symbol to byte decoder.
//
// Request channel (req_valid/req_ready, req_payload): one demodulated chirp bin per
// request; start_frame opens a new frame with this symbol as the first header symbol.
// Response channel (rsp_valid/rsp_ready, rsp_payload): header accept/reject, payload
// bytes and abort notices; last marks the final response caused by one request.
// Configuration: csr_we writes csr_wdata into register csr_index.
// Sequencing: a payload symbol that does not complete a block, header symbols before
// the eighth and symbols outside a frame are taken with no decode. The eighth header
// symbol runs the header decode over eight stored symbols plus SPREAD_FACTOR-7 nibble
// steps; a symbol that completes a payload block runs coding rate decode steps and
// SPREAD_FACTOR nibble steps. The shared deinterleave step takes one stored symbol per
// cycle and the dewhitener one nibble per cycle while the output register is free.
// Responses go through a single output register; when the receiver stalls, the
// sequencer holds until the register is free, and new requests wait until done.
// Reset is synchronous: configuration returns to its defaults and no frame is open.
`timescale 1ns / 1ps
`default_nettype none
module chirp_symbol_to_byte_decoder_core #(
   parameter int SPREAD_FACTOR = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  csbd_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output csbd_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_we,
   input  csbd_pkg::csr_index_type   csr_index,
   input  csbd_pkg::csr_data_type    csr_wdata
);
   import csbd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   csbd_ctrl #(.SF(SPREAD_FACTOR)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_start (req_payload.start_frame),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   csbd_datapath #(.SF(SPREAD_FACTOR)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
